@@ src/brfm_pkg.sv @@
// Package: sizes and operation codes for the byte ring FIFO with pattern match.
`default_nettype none
package brfm_pkg;

	localparam int DEPTH = 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = 9;
	localparam int DW    = 8;

	localparam logic [2:0] KIND_PUT_OVR = 3'd0;
	localparam logic [2:0] KIND_PUT_CHK = 3'd1;
	localparam logic [2:0] KIND_GET     = 3'd2;
	localparam logic [2:0] KIND_CMP     = 3'd3;
	localparam logic [2:0] KIND_CLR     = 3'd4;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef struct packed {
		logic            is_cmp;
		logic            is_clr;
		logic            first;
		logic            last;
		logic            idx_fail;
		logic [DW-1:0]   data;
		logic            get_ok;
		logic            ok;
		logic [CNT_W-1:0] count;
		logic            full;
		logic            empty;
	} s1_t;

endpackage
`default_nettype wire

@@ src/brfm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module brfm_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/byte_ring_fifo_with_match_top.sv @@
// Top level: byte ring FIFO with overwrite, checked put, get, clear and pattern compare.
// Accepted requests are registered in stage s1, then into the output registers.
// Throughput: one request per cycle while the result side is not stalled;
// the storage read port and the pointer update bound this to one per cycle.
// Reset: FIFO empty, capacity 256, compare state cleared; storage is not cleared.
// A capacity write also empties the FIFO and clears the compare state.
`default_nettype none
module byte_ring_fifo_with_match_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] kind,
	input  wire logic [7:0] data,
	input  wire logic       first,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data,
	output logic            ok,
	output logic            match,
	output logic            match_valid,
	output logic [8:0]      count,
	output logic            is_full,
	output logic            is_empty
);

	localparam int AW    = brfm_pkg::AW;
	localparam int CNT_W = brfm_pkg::CNT_W;
	localparam int DW    = brfm_pkg::DW;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= cap) ? '0 : AW'(n);
	endfunction

	function automatic logic [CNT_W-1:0] occ(input logic f, input logic [AW-1:0] w,
			input logic [AW-1:0] r, input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] res;
		if (f) begin
			res = cap;
		end else if (w >= r) begin
			res = CNT_W'(w) - CNT_W'(r);
		end else begin
			res = cap + CNT_W'(w) - CNT_W'(r);
		end
		return res;
	endfunction

	logic [CNT_W-1:0] capacity_q;
	logic [AW-1:0]    wp_q, rp_q;
	logic             full_q;
	logic [CNT_W-1:0] cidx_q;
	logic             fail_q;

	logic             s1_valid_q;
	brfm_pkg::s1_t    s1_s1;

	logic             out_valid_q;
	logic [DW-1:0]    read_data_q;
	logic             ok_q, match_q, match_valid_q, full_out_q, empty_out_q;
	logic [CNT_W-1:0] count_q;

	logic             cfg_wr, in_acc, adv_out;
	logic [DW-1:0]    rdata;

	logic [CNT_W-1:0] cap_eff, n_old, ci_eff, cidx_n, count_n;
	logic [CNT_W:0]   pos_sum, pos;
	logic [AW-1:0]    wp_n, rp_n, raddr;
	logic             full_n, old_empty, empty_n, we, do_store;
	logic             ok_n, get_ok_n, idx_fail_n;
	brfm_pkg::s1_t    s1_n;
	logic             fail_n;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign adv_out   = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !adv_out;
	assign in_acc    = in_valid && !in_stall;

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (capacity_q > brfm_pkg::DEPTH_CNT) begin
			cap_eff = brfm_pkg::DEPTH_CNT;
		end else begin
			cap_eff = capacity_q;
		end
	end

	always_comb begin
		old_empty  = !full_q && (wp_q == rp_q);
		n_old      = occ(full_q, wp_q, rp_q, cap_eff);
		ci_eff     = first ? '0 : cidx_q;
		pos_sum    = {1'b0, CNT_W'(rp_q)} + {1'b0, ci_eff};
		pos        = (pos_sum >= {1'b0, cap_eff}) ? pos_sum - {1'b0, cap_eff} : pos_sum;
		wp_n       = wp_q;
		rp_n       = rp_q;
		full_n     = full_q;
		cidx_n     = cidx_q;
		ok_n       = 1'b1;
		get_ok_n   = 1'b0;
		idx_fail_n = 1'b0;
		raddr      = rp_q;
		do_store   = 1'b0;
		unique case (kind)
			brfm_pkg::KIND_PUT_OVR: begin
				do_store = 1'b1;
			end
			brfm_pkg::KIND_PUT_CHK: begin
				if (full_q) begin
					ok_n = 1'b0;
				end else begin
					do_store = 1'b1;
				end
			end
			brfm_pkg::KIND_GET: begin
				if (old_empty) begin
					ok_n = 1'b0;
				end else begin
					get_ok_n = 1'b1;
					full_n   = 1'b0;
					rp_n     = wrap_inc(rp_q, cap_eff);
				end
			end
			brfm_pkg::KIND_CMP: begin
				raddr      = AW'(pos);
				idx_fail_n = (ci_eff >= n_old);
				if (last) begin
					cidx_n = '0;
				end else if (ci_eff != '1) begin
					cidx_n = ci_eff + CNT_W'(1);
				end else begin
					cidx_n = ci_eff;
				end
			end
			brfm_pkg::KIND_CLR: begin
				wp_n   = '0;
				rp_n   = '0;
				full_n = 1'b0;
				cidx_n = '0;
			end
			default: begin
			end
		endcase
		if (do_store) begin
			if (full_q) begin
				rp_n = wrap_inc(rp_q, cap_eff);
			end
			wp_n   = wrap_inc(wp_q, cap_eff);
			full_n = (wp_n == rp_n);
		end
		we      = in_acc && do_store;
		count_n = occ(full_n, wp_n, rp_n, cap_eff);
		empty_n = !full_n && (wp_n == rp_n);

		s1_n.is_cmp   = (kind == brfm_pkg::KIND_CMP);
		s1_n.is_clr   = (kind == brfm_pkg::KIND_CLR);
		s1_n.first    = first;
		s1_n.last     = last;
		s1_n.idx_fail = idx_fail_n;
		s1_n.data     = data;
		s1_n.get_ok   = get_ok_n;
		s1_n.ok       = ok_n;
		s1_n.count    = count_n;
		s1_n.full     = full_n;
		s1_n.empty    = empty_n;
	end

	brfm_ram #(
		.AW(AW),
		.DW(DW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (data),
		.re    (in_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= brfm_pkg::CAP_RESET;
			wp_q       <= '0;
			rp_q       <= '0;
			full_q     <= 1'b0;
			cidx_q     <= '0;
		end else if (cfg_wr) begin
			capacity_q <= cfg_data;
			wp_q       <= '0;
			rp_q       <= '0;
			full_q     <= 1'b0;
			cidx_q     <= '0;
		end else if (in_acc) begin
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			full_q <= full_n;
			cidx_q <= cidx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv_out) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_s1 <= s1_n;
		end
	end

	// running mismatch flag of the pattern in flight
	assign fail_n = (s1_s1.first ? 1'b0 : fail_q) | s1_s1.idx_fail | (rdata != s1_s1.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fail_q      <= 1'b0;
		end else begin
			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
			if (cfg_wr) begin
				fail_q <= 1'b0;
			end else if (adv_out && s1_valid_q) begin
				if (s1_s1.is_clr) begin
					fail_q <= 1'b0;
				end else if (s1_s1.is_cmp) begin
					fail_q <= s1_s1.last ? 1'b0 : fail_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && s1_valid_q) begin
			read_data_q   <= s1_s1.get_ok ? rdata : '0;
			ok_q          <= s1_s1.ok;
			match_valid_q <= s1_s1.is_cmp && s1_s1.last;
			match_q       <= s1_s1.is_cmp && s1_s1.last && !fail_n;
			count_q       <= s1_s1.count;
			full_out_q    <= s1_s1.full;
			empty_out_q   <= s1_s1.empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign ok          = ok_q;
	assign match       = match_q;
	assign match_valid = match_valid_q;
	assign count       = count_q;
	assign is_full     = full_out_q;
	assign is_empty    = empty_out_q;

endmodule
`default_nettype wire
